[rtl/throughput_driven_concurrency_window_top_assert.svh]
// ----------------------------------------------------------------------------
// Concurrency window assertion macros
// Shared property macros for the concurrency window controller checks.
// ----------------------------------------------------------------------------
`ifndef THROUGHPUT_DRIVEN_CONCURRENCY_WINDOW_TOP_ASSERT_SVH
`define THROUGHPUT_DRIVEN_CONCURRENCY_WINDOW_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TDCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("concurrency window check failed");
`define TDCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("concurrency window sequence check failed");
`else
`define TDCW_ASSERT_IMP(lbl, ante, cons)
`define TDCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/tdcw_pkg.sv]
// ----------------------------------------------------------------------------
// Concurrency window package
// Constants, codes and inter-module structs of the concurrency window block.
// ----------------------------------------------------------------------------
package tdcw_pkg;

    localparam int C_MAX_THREADS = 64;
    localparam int C_IDX_W       = $clog2(C_MAX_THREADS);
    localparam int C_WIN_W       = 7;
    localparam int C_RATE_W      = 24;
    localparam logic [C_RATE_W-1:0] C_RATE_MAX = {C_RATE_W{1'b1}};

    // Shared divider: 32-bit count shifted up by 8, over a 16-bit divisor.
    localparam int C_DIV_NW    = 40;
    localparam int C_DIV_DW    = 16;
    localparam int C_DIV_CW    = $clog2(C_DIV_NW + 1);

    // Input word kinds.
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_QUERY    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THREADS  = 2'd0;
    localparam logic [1:0] CFG_DIVISOR  = 2'd1;
    localparam logic [1:0] CFG_SLOW_LIM = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic                en;
        logic [C_IDX_W-1:0]  addr;
        logic [C_RATE_W-1:0] data;
    } t_hist_wr;

    typedef struct packed {
        logic               en;
        logic [C_IDX_W-1:0] lo;
        logic [C_IDX_W-1:0] hi;
    } t_hist_clr;

endpackage

[rtl/tdcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tdcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tdcw_div.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; used for the rate and the shrink size.
// ----------------------------------------------------------------------------
module tdcw_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tdcw_pkg::C_DIV_NW-1:0]    i_dividend,
    input  logic [tdcw_pkg::C_DIV_DW-1:0]    i_divisor,
    output tdcw_pkg::t_div_stat              o_stat,
    output logic [tdcw_pkg::C_DIV_NW-1:0]    o_quotient
);
    import tdcw_pkg::*;

    logic [C_DIV_CW-1:0] r_cnt;
    logic                r_done;
    logic [C_DIV_NW-1:0] r_quo;
    logic [C_DIV_DW-1:0] r_rem;
    logic [C_DIV_DW-1:0] r_dvs;

    logic [C_DIV_DW:0]   rem_sh;
    logic                ge;
    logic [C_DIV_DW:0]   rem_diff;

    // A zero divisor yields an all-ones quotient, which the caller saturates.
    assign rem_sh   = {r_rem, r_quo[C_DIV_NW-1]};
    assign ge       = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == C_DIV_CW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= C_DIV_CW'(C_DIV_NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - C_DIV_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[C_DIV_NW-2:0], ge};
            r_rem <= ge ? rem_diff[C_DIV_DW-1:0] : rem_sh[C_DIV_DW-1:0];
        end
    end

    assign o_stat.busy = r_cnt != '0;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[rtl/tdcw_hist.sv]
// ----------------------------------------------------------------------------
// Rate history store
// RAM of recorded rates per window size, with per-entry valid flags so that
// reset and range clears take effect at once.
// ----------------------------------------------------------------------------
module tdcw_hist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [tdcw_pkg::C_IDX_W-1:0]    i_rd_addr,
    output logic [tdcw_pkg::C_RATE_W-1:0]   o_rd_data,
    input  tdcw_pkg::t_hist_wr              i_wr,
    input  tdcw_pkg::t_hist_clr             i_clr
);
    import tdcw_pkg::*;

    logic [C_MAX_THREADS-1:0] r_vld;
    logic                     r_rd_vld;
    logic [C_RATE_W-1:0]      ram_q;

    tdcw_ram #(
        .WIDTH (C_RATE_W),
        .DEPTH (C_MAX_THREADS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            for (int k = 0; k < C_MAX_THREADS; k++) begin
                if (i_clr.en && (C_IDX_W'(k) >= i_clr.lo) && (C_IDX_W'(k) <= i_clr.hi)) begin
                    r_vld[k] <= 1'b0;
                end else if (i_wr.en && (i_wr.addr == C_IDX_W'(k))) begin
                    r_vld[k] <= 1'b1;
                end
            end
        end
    end

    // An entry never written since reset or since its last clear reads as zero.
    assign o_rd_data = r_rd_vld ? ram_q : '0;

endmodule

[rtl/throughput_driven_concurrency_window_top.sv]
// ----------------------------------------------------------------------------
// Throughput driven concurrency window
// AIMD controller of how many worker threads may run, driven by completion
// counts and periodic throughput samples.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_axis    in         tuser: action; tdata: thread_id, elapsed_ms
// m_axis    out        tdata: window_size, admitted, current_rate,
//                      released_thread, release_valid
// apb       in/out     worker thread limit, shrink_divisor, slowdown_limit
//
// Completions, queries and unknown words are answered from the idle state.
// A sample tick runs the 40 steps of the shared one-bit-per-cycle divider;
// a tick that triggers the multiplicative decrease runs the divider again.
// Reset is synchronous; the history valid flags clear at once, no sweep.
// A stalled result word holds off the next input word.
// ----------------------------------------------------------------------------
`include "throughput_driven_concurrency_window_top_assert.svh"

module throughput_driven_concurrency_window_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [5:0] thread_id, [21:6] elapsed_ms, [23:22] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    // Result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [6:0] window_size, [7] admitted,
                                       // [31:8] current_rate, [37:32] released_thread,
                                       // [38] release_valid, [39] zero
);
    import tdcw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDIV = 5'b00010,
        S_CMP  = 5'b00100,
        S_SDIV = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Configuration
    logic [6:0] r_thr;
    logic [7:0] r_dvsr;
    logic [7:0] r_lim;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 7'd64;
            r_dvsr <= 8'd32;
            r_lim  <= 8'd3;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_THREADS:  r_thr  <= pwdata[6:0];
                CFG_DIVISOR:  r_dvsr <= pwdata[7:0];
                CFG_SLOW_LIM: r_lim  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_THREADS:  prdata = {25'd0, r_thr};
            CFG_DIVISOR:  prdata = {24'd0, r_dvsr};
            CFG_SLOW_LIM: prdata = {24'd0, r_lim};
            default:      prdata = '0;
        endcase
    end

    // State
    t_state              r_state, n_state;
    logic [C_WIN_W-1:0]  r_win, n_win;
    logic                r_phase, n_phase;
    logic [7:0]          r_slow, n_slow;
    logic [31:0]         r_ops, n_ops;
    logic [C_RATE_W-1:0] r_rate, n_rate;
    logic [C_IDX_W-1:0]  r_rel_id, n_rel_id;
    logic                r_rel_v, n_rel_v;

    // Output register
    logic                r_m_valid, n_m_valid;
    logic [C_WIN_W-1:0]  r_m_win, n_m_win;
    logic                r_m_adm, n_m_adm;
    logic [C_RATE_W-1:0] r_m_rate, n_m_rate;
    logic [C_IDX_W-1:0]  r_m_rel, n_m_rel;
    logic                r_m_relv, n_m_relv;

    // Input fields
    logic [1:0]  s_action;
    logic [5:0]  s_tid;
    logic [15:0] s_elapsed;
    logic        s_acc;
    logic        out_free;

    assign s_action  = s_axis_tuser;
    assign s_tid     = s_axis_tdata[5:0];
    assign s_elapsed = s_axis_tdata[21:6];
    assign out_free  = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_acc     = s_axis_tvalid && s_axis_tready;

    // Shared divider and history store
    logic                div_start;
    logic [C_DIV_NW-1:0] div_dividend;
    logic [C_DIV_DW-1:0] div_divisor;
    t_div_stat           div_stat;
    logic [C_DIV_NW-1:0] div_quo;

    tdcw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    logic [C_IDX_W-1:0]  hist_rd_addr;
    logic [C_RATE_W-1:0] hist_rd;
    t_hist_wr            hist_wr;
    t_hist_clr           hist_clr;

    // The window is stable through a tick, so the entry below it is read early.
    assign hist_rd_addr = C_IDX_W'(r_win - C_WIN_W'(2));

    tdcw_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_rd),
        .i_wr      (hist_wr),
        .i_clr     (hist_clr)
    );

    // Derived values
    logic [C_WIN_W-1:0]  tc;
    logic [C_RATE_W-1:0] rate_sat;
    logic                better;
    logic [7:0]          slow_inc;
    logic [7:0]          win_p1;
    logic [7:0]          dvsr_eff;
    logic [10:0]         nm0, nm1, nm2, nm3;

    always_comb begin
        if (r_thr == '0) begin
            tc = C_WIN_W'(1);
        end else if (r_thr > C_WIN_W'(C_MAX_THREADS)) begin
            tc = C_WIN_W'(C_MAX_THREADS);
        end else begin
            tc = r_thr;
        end
    end

    assign rate_sat = (div_quo[C_DIV_NW-1:C_RATE_W] != '0) ? C_RATE_MAX
                                                           : div_quo[C_RATE_W-1:0];
    assign better   = (r_win <= C_WIN_W'(1)) || (r_rate > hist_rd);
    assign slow_inc = r_slow + 8'd1;
    assign win_p1   = {1'b0, r_win} + 8'd1;
    assign dvsr_eff = (r_dvsr == 8'd0) ? 8'd1 : r_dvsr;

    // New size after the multiplicative decrease: cap, force a change, floor at one.
    assign nm0 = div_quo[10:0];
    assign nm1 = (nm0 > 11'(tc)) ? 11'(tc) : nm0;
    assign nm2 = (nm1 == 11'(r_win)) ? nm1 - 11'd1 : nm1;
    assign nm3 = (nm2 == 11'd0) ? 11'd1 : nm2;

    always_comb begin
        n_state   = r_state;
        n_win     = r_win;
        n_phase   = r_phase;
        n_slow    = r_slow;
        n_ops     = r_ops;
        n_rate    = r_rate;
        n_rel_id  = r_rel_id;
        n_rel_v   = r_rel_v;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_win   = r_m_win;
        n_m_adm   = r_m_adm;
        n_m_rate  = r_m_rate;
        n_m_rel   = r_m_rel;
        n_m_relv  = r_m_relv;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        hist_wr      = '0;
        hist_clr     = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_m_win  = r_win;
                    n_m_adm  = 1'b0;
                    n_m_rate = '0;
                    n_m_rel  = '0;
                    n_m_relv = 1'b0;
                    case (s_action)
                        ACT_TICK: begin
                            div_start    = 1'b1;
                            div_dividend = {r_ops, 8'd0};
                            div_divisor  = s_elapsed;
                            n_ops        = '0;
                            n_rel_id     = '0;
                            n_rel_v      = 1'b0;
                            n_state      = S_RDIV;
                        end
                        ACT_COMPLETE: begin
                            n_ops     = r_ops + 32'd1;
                            n_m_valid = 1'b1;
                        end
                        ACT_QUERY: begin
                            n_m_adm   = C_WIN_W'(s_tid) < r_win;
                            n_m_valid = 1'b1;
                        end
                        default: begin
                            n_m_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RDIV: begin
                if (div_stat.done) begin
                    n_rate  = rate_sat;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_DONE;
                if (better) begin
                    if (!r_phase) begin
                        hist_wr.en   = 1'b1;
                        hist_wr.addr = C_IDX_W'(r_win - C_WIN_W'(1));
                        hist_wr.data = r_rate;
                    end
                    n_phase = 1'b0;
                    n_slow  = '0;
                    if (r_win < tc) begin
                        n_win    = r_win + C_WIN_W'(1);
                        n_rel_id = C_IDX_W'(r_win);
                        n_rel_v  = 1'b1;
                    end
                end else if (!r_phase) begin
                    n_win   = r_win - C_WIN_W'(1);
                    n_phase = 1'b1;
                end else if (slow_inc == r_lim) begin
                    div_start    = 1'b1;
                    div_dividend = C_DIV_NW'({win_p1, 4'd0});
                    div_divisor  = C_DIV_DW'(dvsr_eff);
                    n_state      = S_SDIV;
                end else begin
                    n_slow = slow_inc;
                end
            end
            S_SDIV: begin
                if (div_stat.done) begin
                    hist_clr.en = 1'b1;
                    hist_clr.lo = C_IDX_W'(nm3 - 11'd1);
                    hist_clr.hi = C_IDX_W'(tc - C_WIN_W'(1));
                    n_win       = C_WIN_W'(nm3);
                    n_phase     = 1'b0;
                    n_slow      = '0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_win   = r_win;
                    n_m_adm   = 1'b0;
                    n_m_rate  = r_rate;
                    n_m_rel   = r_rel_id;
                    n_m_relv  = r_rel_v;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win     <= C_WIN_W'(1);
            r_phase   <= 1'b0;
            r_slow    <= '0;
            r_ops     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win     <= n_win;
            r_phase   <= n_phase;
            r_slow    <= n_slow;
            r_ops     <= n_ops;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate   <= n_rate;
        r_rel_id <= n_rel_id;
        r_rel_v  <= n_rel_v;
        r_m_win  <= n_m_win;
        r_m_adm  <= n_m_adm;
        r_m_rate <= n_m_rate;
        r_m_rel  <= n_m_rel;
        r_m_relv <= n_m_relv;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_relv, r_m_rel, r_m_rate, r_m_adm, r_m_win};

    `TDCW_ASSERT_IMP(a_win_range, 1'b1, (r_win != '0) && (r_win <= C_WIN_W'(C_MAX_THREADS)))
    `TDCW_ASSERT_NXT(a_tick_starts_div, s_acc && (s_action == ACT_TICK), (r_state == S_RDIV) && div_stat.busy)
    `TDCW_ASSERT_IMP(a_div_running, (r_state == S_RDIV) || (r_state == S_SDIV), div_stat.busy || div_stat.done)
    `TDCW_ASSERT_IMP(a_release_matches, m_axis_tvalid && r_m_relv, r_m_win == C_WIN_W'(r_m_rel) + C_WIN_W'(1))

endmodule
